// File: rtl/aabb_push_out_resolver_top_defines.svh
// ----------------------------------------------------------------------------
// AABB push-out resolver assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef AABB_PUSH_OUT_RESOLVER_TOP_DEFINES_SVH
`define AABB_PUSH_OUT_RESOLVER_TOP_DEFINES_SVH

// same-cycle implication
`define APOR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APOR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/apor_pkg.sv
// ----------------------------------------------------------------------------
// AABB push-out resolver package
// Widths, packing offsets, register indexes and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package apor_pkg;

    localparam int COORD_BITS  = 32;
    localparam int SIZE_BITS   = 31;
    localparam int MARGIN_BITS = 16;
    localparam int CFG_BITS    = SIZE_BITS;

    // intermediate width: covers edges, overlaps and pushed positions exactly
    localparam int BASE_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int EXT_BITS  = BASE_BITS + 3;

    // input tdata layout
    localparam int IN_PX_LO  = 0;
    localparam int IN_PY_LO  = IN_PX_LO + COORD_BITS;
    localparam int IN_WX_LO  = IN_PY_LO + COORD_BITS;
    localparam int IN_WY_LO  = IN_WX_LO + COORD_BITS;
    localparam int IN_WW_LO  = IN_WY_LO + COORD_BITS;
    localparam int IN_WH_LO  = IN_WW_LO + SIZE_BITS;
    localparam int IN_BITS   = IN_WH_LO + SIZE_BITS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // input tuser layout
    localparam int IN_TUSER_W = 2;
    localparam int USR_START  = 0;
    localparam int USR_WALL   = 1;

    // output tdata layout
    localparam int OUT_BITS    = 2 * COORD_BITS + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic {
        CFG_PLAYER_SIZE = 1'b0,
        CFG_PUSH_MARGIN = 1'b1
    } t_cfg_idx;

    localparam logic [SIZE_BITS-1:0]   SIZE_RST   = SIZE_BITS'(65536);
    localparam logic [MARGIN_BITS-1:0] MARGIN_RST = MARGIN_BITS'(66);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [EXT_BITS-1:0]   t_ext;

    typedef struct packed {
        logic push_x;
        logic push_y;
    } t_push;

    localparam t_ext EXT_CMAX = {{(EXT_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam t_ext EXT_CMIN = {{(EXT_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    function automatic t_coord sat_coord(input t_ext v);
        t_coord r;
        if (v > EXT_CMAX) begin
            r = EXT_CMAX[COORD_BITS-1:0];
        end else if (v < EXT_CMIN) begin
            r = EXT_CMIN[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/apor_resolve.sv
// ----------------------------------------------------------------------------
// AABB push-out resolve datapath
// Overlap test of player square against one wall and minimum-axis push-out.
// ----------------------------------------------------------------------------
`default_nettype none

module apor_resolve (
    input  wire apor_pkg::t_coord                   i_cur_x,
    input  wire apor_pkg::t_coord                   i_cur_y,
    input  wire                                     i_wall_present,
    input  wire apor_pkg::t_coord                   i_wall_x,
    input  wire apor_pkg::t_coord                   i_wall_y,
    input  wire [apor_pkg::SIZE_BITS-1:0]           i_wall_width,
    input  wire [apor_pkg::SIZE_BITS-1:0]           i_wall_height,
    input  wire [apor_pkg::SIZE_BITS-1:0]           i_player_size,
    input  wire [apor_pkg::MARGIN_BITS-1:0]         i_push_margin,
    output apor_pkg::t_coord                        o_new_x,
    output apor_pkg::t_coord                        o_new_y,
    output apor_pkg::t_push                         o_push
);
    import apor_pkg::*;

    t_ext cx, cy, wx, wy, h, hx, hy, m;
    t_ext pl, pr, pb, pt, wl, wr, wb, wt;
    t_ext ox_a, ox_b, oy_a, oy_b, ox, oy;
    logic hit;

    // half sizes are floor(size / 2)
    assign h  = {{(EXT_BITS-SIZE_BITS+1){1'b0}}, i_player_size[SIZE_BITS-1:1]};
    assign hx = {{(EXT_BITS-SIZE_BITS+1){1'b0}}, i_wall_width[SIZE_BITS-1:1]};
    assign hy = {{(EXT_BITS-SIZE_BITS+1){1'b0}}, i_wall_height[SIZE_BITS-1:1]};
    assign m  = {{(EXT_BITS-MARGIN_BITS){1'b0}}, i_push_margin};

    assign cx = EXT_BITS'(i_cur_x);
    assign cy = EXT_BITS'(i_cur_y);
    assign wx = EXT_BITS'(i_wall_x);
    assign wy = EXT_BITS'(i_wall_y);

    assign pl = cx - h;
    assign pr = cx + h;
    assign pb = cy - h;
    assign pt = cy + h;
    assign wl = wx - hx;
    assign wr = wx + hx;
    assign wb = wy - hy;
    assign wt = wy + hy;

    // touching edges do not count
    assign hit = i_wall_present && (pr > wl) && (pl < wr) && (pt > wb) && (pb < wt);

    assign ox_a = pr - wl;
    assign ox_b = wr - pl;
    assign oy_a = pt - wb;
    assign oy_b = wt - pb;
    assign ox   = (ox_b < ox_a) ? ox_b : ox_a;
    assign oy   = (oy_b < oy_a) ? oy_b : oy_a;

    always_comb begin
        o_new_x = i_cur_x;
        o_new_y = i_cur_y;
        o_push  = '0;
        if (hit) begin
            // Y axis wins ties
            if (ox < oy) begin
                o_new_x = sat_coord((i_cur_x > i_wall_x) ? (cx + (ox + m)) : (cx - (ox + m)));
                o_push.push_x = 1'b1;
            end else begin
                o_new_y = sat_coord((i_cur_y > i_wall_y) ? (cy + (oy + m)) : (cy - (oy + m)));
                o_push.push_y = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/aabb_push_out_resolver_top.sv
// Path: a last item goes through one input register and one result register; it waits
//   in the input register while a stalled earlier result holds the result register.
// Throughput: one item per cycle while no last item waits on the output; each item is
//   resolved from its input register, and its updated position feeds the next item.
// Reset: synchronous active low; position, stop flags and valids clear, registers
//   return to player_size = 1.0 and push_margin = 66 (Q16.16).
// ----------------------------------------------------------------------------
// AABB push-out resolver top level
// Streams walls against a square player and emits the resolved position on last.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_push_out_resolver_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write port
    input  wire                                 i_cfg_we,
    input  wire                                 i_cfg_idx,
    input  wire [apor_pkg::CFG_BITS-1:0]        i_cfg_data,
    // input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // player_x, player_y, wall_x, wall_y, wall_width, wall_height, zero pad
    input  wire [apor_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // start_req, wall_present
    input  wire [apor_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    input  wire                                 s_axis_tlast,
    // output stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // out_x, out_y, stopped_x, stopped_y, zero pad
    output logic [apor_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import apor_pkg::*;

    `include "aabb_push_out_resolver_top_defines.svh"

    logic [SIZE_BITS-1:0]   r_player_size;
    logic [MARGIN_BITS-1:0] r_push_margin;

    logic                   r_in_valid;
    logic                   r_in_start;
    logic                   r_in_wall;
    logic                   r_in_last;
    t_coord                 r_in_px, r_in_py, r_in_wx, r_in_wy;
    logic [SIZE_BITS-1:0]   r_in_ww, r_in_wh;

    t_coord                 r_cur_x, r_cur_y;
    logic                   r_stop_x, r_stop_y;

    logic                   r_out_valid;
    t_coord                 r_out_x, r_out_y;
    logic                   r_out_sx, r_out_sy;

    logic                   w_adv;
    t_coord                 w_base_x, w_base_y, w_new_x, w_new_y;
    logic                   w_base_sx, w_base_sy;
    logic                   n_stop_x, n_stop_y;
    t_push                  w_push;

    // a non-last item never needs the output register
    assign w_adv = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_size <= SIZE_RST;
            r_push_margin <= MARGIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PLAYER_SIZE: r_player_size <= i_cfg_data[SIZE_BITS-1:0];
                CFG_PUSH_MARGIN: r_push_margin <= i_cfg_data[MARGIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_start <= s_axis_tuser[USR_START];
            r_in_wall  <= s_axis_tuser[USR_WALL];
            r_in_last  <= s_axis_tlast;
            r_in_px    <= s_axis_tdata[IN_PX_LO +: COORD_BITS];
            r_in_py    <= s_axis_tdata[IN_PY_LO +: COORD_BITS];
            r_in_wx    <= s_axis_tdata[IN_WX_LO +: COORD_BITS];
            r_in_wy    <= s_axis_tdata[IN_WY_LO +: COORD_BITS];
            r_in_ww    <= s_axis_tdata[IN_WW_LO +: SIZE_BITS];
            r_in_wh    <= s_axis_tdata[IN_WH_LO +: SIZE_BITS];
        end
    end

    // start loads the player and clears the flags before this item's wall
    assign w_base_x  = r_in_start ? r_in_px : r_cur_x;
    assign w_base_y  = r_in_start ? r_in_py : r_cur_y;
    assign w_base_sx = r_in_start ? 1'b0 : r_stop_x;
    assign w_base_sy = r_in_start ? 1'b0 : r_stop_y;

    apor_resolve u_resolve (
        .i_cur_x        (w_base_x),
        .i_cur_y        (w_base_y),
        .i_wall_present (r_in_wall),
        .i_wall_x       (r_in_wx),
        .i_wall_y       (r_in_wy),
        .i_wall_width   (r_in_ww),
        .i_wall_height  (r_in_wh),
        .i_player_size  (r_player_size),
        .i_push_margin  (r_push_margin),
        .o_new_x        (w_new_x),
        .o_new_y        (w_new_y),
        .o_push         (w_push)
    );

    assign n_stop_x = w_base_sx || w_push.push_x;
    assign n_stop_y = w_base_sy || w_push.push_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_stop_x <= 1'b0;
            r_stop_y <= 1'b0;
        end else if (w_adv) begin
            r_cur_x  <= w_new_x;
            r_cur_y  <= w_new_y;
            r_stop_x <= n_stop_x;
            r_stop_y <= n_stop_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_x  <= w_new_x;
            r_out_y  <= w_new_y;
            r_out_sx <= n_stop_x;
            r_out_sy <= n_stop_y;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, r_out_sy, r_out_sx,
                            r_out_y, r_out_x};

    `APOR_ASSERT_NEXT(a_out_from_last, !r_out_valid && !(w_adv && r_in_last), !r_out_valid,
        "result appeared without a last item")
    `APOR_ASSERT_SAME(a_one_axis, 1'b1, !(w_push.push_x && w_push.push_y),
        "push on both axes for one wall")
    `APOR_ASSERT_NEXT(a_start_clears, w_adv && r_in_start && !r_in_wall,
        !r_stop_x && !r_stop_y, "start without wall left a stop flag set")
    `APOR_ASSERT_NEXT(a_in_hold, r_in_valid && !w_adv, r_in_valid,
        "held item dropped from input register")

endmodule

`default_nettype wire

// File: dv/aabb_push_out_resolver_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AABB push-out resolver testbench
// Streams player starts and wall boxes into the resolver under several
// register settings, predicts each resolved position and stop flag pair, and
// compares every output item against the prediction. Both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module aabb_push_out_resolver_top_test;

    import apor_pkg::*;

    localparam longint COORD_MAX    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN    = -(longint'(1) <<< (COORD_BITS - 1));
    localparam longint Q_ONE        = 65536;
    localparam longint SIZE_FULL    = (longint'(1) <<< SIZE_BITS) - 1;
    localparam int     ITEM_TARGET  = 1850;
    localparam int     DIRECTED_N   = 21;
    localparam int     PHASES       = 8;
    localparam int     IDLE_LIMIT   = 2000;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     PRINT_CAP    = 40;

    typedef struct {
        logic                 start;
        t_coord               px;
        t_coord               py;
        logic                 wall;
        t_coord               wx;
        t_coord               wy;
        logic [SIZE_BITS-1:0] ww;
        logic [SIZE_BITS-1:0] wh;
        logic                 last;
    } t_wall_step;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   stop_x;
        logic   stop_y;
    } t_resolved;

    // Tracks the player position the way the block should, one item at a time.
    class push_out_scoreboard;
        logic [SIZE_BITS-1:0]   size_reg   = SIZE_RST;
        logic [MARGIN_BITS-1:0] margin_reg = MARGIN_RST;
        longint    pos_x;
        longint    pos_y;
        bit        stop_x;
        bit        stop_y;
        t_resolved expected_pos[$];
        int        n_errors;
        int        n_checked;

        function void set_reg(t_cfg_idx idx, logic [CFG_BITS-1:0] value);
            if (idx == CFG_PLAYER_SIZE) begin
                size_reg = value[SIZE_BITS-1:0];
            end else begin
                margin_reg = value[MARGIN_BITS-1:0];
            end
        endfunction

        function longint clamp(longint v);
            if (v > COORD_MAX) return COORD_MAX;
            if (v < COORD_MIN) return COORD_MIN;
            return v;
        endfunction

        function void push_out(longint wx, longint wy,
                               logic [SIZE_BITS-1:0] ww, logic [SIZE_BITS-1:0] wh);
            longint half, hx, hy, m, pl, pr, pb, pt, wl, wr, wb, wt, ox, oy;
            half = longint'(size_reg >> 1);
            hx   = longint'(ww >> 1);
            hy   = longint'(wh >> 1);
            m    = longint'(margin_reg);
            pl = pos_x - half;
            pr = pos_x + half;
            pb = pos_y - half;
            pt = pos_y + half;
            wl = wx - hx;
            wr = wx + hx;
            wb = wy - hy;
            wt = wy + hy;
            // strict overlap only; shared edges leave the player alone
            if (!(pr > wl && pl < wr && pt > wb && pb < wt)) return;
            ox = (wr - pl < pr - wl) ? wr - pl : pr - wl;
            oy = (wt - pb < pt - wb) ? wt - pb : pt - wb;
            // Y takes ties
            if (ox < oy) begin
                pos_x  = clamp(pos_x > wx ? pos_x + (ox + m) : pos_x - (ox + m));
                stop_x = 1'b1;
            end else begin
                pos_y  = clamp(pos_y > wy ? pos_y + (oy + m) : pos_y - (oy + m));
                stop_y = 1'b1;
            end
        endfunction

        function void note_item(t_wall_step it);
            t_resolved r;
            if (it.start) begin
                pos_x  = longint'(it.px);
                pos_y  = longint'(it.py);
                stop_x = 1'b0;
                stop_y = 1'b0;
            end
            if (it.wall) push_out(longint'(it.wx), longint'(it.wy), it.ww, it.wh);
            if (it.last) begin
                r.x      = t_coord'(pos_x);
                r.y      = t_coord'(pos_y);
                r.stop_x = stop_x;
                r.stop_y = stop_y;
                expected_pos.push_back(r);
            end
        endfunction

        task flag_mismatch(string msg);
            n_errors++;
            if (n_errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(t_resolved got);
            t_resolved want;
            if (expected_pos.size() == 0) begin
                flag_mismatch($sformatf("unexpected result x=%0d y=%0d sx=%0b sy=%0b",
                                        got.x, got.y, got.stop_x, got.stop_y));
                return;
            end
            want = expected_pos.pop_front();
            n_checked++;
            if (got.x !== want.x || got.y !== want.y ||
                got.stop_x !== want.stop_x || got.stop_y !== want.stop_y) begin
                flag_mismatch($sformatf(
                    "result %0d got x=%0d y=%0d sx=%0b sy=%0b, want x=%0d y=%0d sx=%0b sy=%0b",
                    n_checked, got.x, got.y, got.stop_x, got.stop_y,
                    want.x, want.y, want.stop_x, want.stop_y));
            end
        endtask
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_idx     = 1'b0;
    logic [CFG_BITS-1:0]    i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    push_out_scoreboard sb;
    t_wall_step         seen_item;
    t_resolved          seen_result;
    int                 items_sent;
    int                 n_settings;
    int                 idle_cycles;
    int                 hold_cnt;
    int                 sink_roll;
    bit                 steady_sender;

    aabb_push_out_resolver_top dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .s_axis_tlast,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // monitor: both handshakes sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen_item.start = s_axis_tuser[USR_START];
                seen_item.wall  = s_axis_tuser[USR_WALL];
                seen_item.px    = s_axis_tdata[IN_PX_LO +: COORD_BITS];
                seen_item.py    = s_axis_tdata[IN_PY_LO +: COORD_BITS];
                seen_item.wx    = s_axis_tdata[IN_WX_LO +: COORD_BITS];
                seen_item.wy    = s_axis_tdata[IN_WY_LO +: COORD_BITS];
                seen_item.ww    = s_axis_tdata[IN_WW_LO +: SIZE_BITS];
                seen_item.wh    = s_axis_tdata[IN_WH_LO +: SIZE_BITS];
                seen_item.last  = s_axis_tlast;
                sb.note_item(seen_item);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen_result.x      = m_axis_tdata[0 +: COORD_BITS];
                seen_result.y      = m_axis_tdata[COORD_BITS +: COORD_BITS];
                seen_result.stop_x = m_axis_tdata[2 * COORD_BITS];
                seen_result.stop_y = m_axis_tdata[2 * COORD_BITS + 1];
                sb.check_result(seen_result);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output side: short stalls mostly, some long ones, some long ready runs
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 55) begin
                m_axis_tready <= 1'b1;
                hold_cnt      <= $urandom_range(0, 8);
            end else if (sink_roll < 88) begin
                m_axis_tready <= 1'b0;
                hold_cnt      <= $urandom_range(0, 3);
            end else if (sink_roll < 96) begin
                m_axis_tready <= 1'b1;
                hold_cnt      <= $urandom_range(20, 80);
            end else begin
                m_axis_tready <= 1'b0;
                hold_cnt      <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_coord near(longint base, int unsigned spread);
        longint off;
        off = longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        return t_coord'(base + off);
    endfunction

    function automatic logic [SIZE_BITS-1:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 20) return SIZE_BITS'($urandom);
        return SIZE_BITS'($urandom_range(1, 4 * 65536));
    endfunction

    function automatic t_wall_step mk(bit start, longint px, longint py, bit wall,
                                      longint wx, longint wy, longint ww, longint wh,
                                      bit last);
        t_wall_step it;
        it.start = start;
        it.px    = t_coord'(px);
        it.py    = t_coord'(py);
        it.wall  = wall;
        it.wx    = t_coord'(wx);
        it.wy    = t_coord'(wy);
        it.ww    = SIZE_BITS'(ww);
        it.wh    = SIZE_BITS'(wh);
        it.last  = last;
        return it;
    endfunction

    task automatic send_item(t_wall_step it);
        int                    gap;
        logic [IN_TDATA_W-1:0] data;
        logic [IN_TUSER_W-1:0] user;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        data = '0;
        data[IN_PX_LO +: COORD_BITS] = it.px;
        data[IN_PY_LO +: COORD_BITS] = it.py;
        data[IN_WX_LO +: COORD_BITS] = it.wx;
        data[IN_WY_LO +: COORD_BITS] = it.wy;
        data[IN_WW_LO +: SIZE_BITS]  = it.ww;
        data[IN_WH_LO +: SIZE_BITS]  = it.wh;
        user = '0;
        user[USR_START] = it.start;
        user[USR_WALL]  = it.wall;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= user;
        s_axis_tlast  <= it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // hold the input until every pending result is out, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_pos.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [SIZE_BITS-1:0] size, logic [MARGIN_BITS-1:0] margin);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PLAYER_SIZE;
        i_cfg_data <= CFG_BITS'(size);
        @(posedge i_clk);
        sb.set_reg(CFG_PLAYER_SIZE, CFG_BITS'(size));
        i_cfg_idx  <= CFG_PUSH_MARGIN;
        i_cfg_data <= CFG_BITS'(margin);
        @(posedge i_clk);
        sb.set_reg(CFG_PUSH_MARGIN, CFG_BITS'(margin));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    task automatic run_directed();
        t_wall_step seq[$];
        seq.push_back(mk(0, 0, 0, 1, 0, 0, Q_ONE, Q_ONE, 0));   // no start: held position
        seq.push_back(mk(0, 0, 0, 0, $urandom, $urandom, $urandom, $urandom, 1));
        seq.push_back(mk(1, 0, 0, 1, Q_ONE, 0, Q_ONE, Q_ONE, 1));   // edges touch in x
        seq.push_back(mk(1, 0, 0, 1, 0, Q_ONE, Q_ONE, Q_ONE, 1));   // edges touch in y
        seq.push_back(mk(1, 0, 0, 1, 20000, 0, Q_ONE, 10 * Q_ONE, 0));
        seq.push_back(mk(0, 0, 0, 1, -60000, 0, Q_ONE, 10 * Q_ONE, 0));
        seq.push_back(mk(0, 0, 0, 1, 0, 20000, 10 * Q_ONE, Q_ONE, 1));
        seq.push_back(mk(1, 0, 0, 1, Q_ONE / 2, Q_ONE / 2, Q_ONE, Q_ONE, 1));   // equal overlaps
        seq.push_back(mk(1, 5 * Q_ONE, -3 * Q_ONE, 1, 5 * Q_ONE, -3 * Q_ONE, 0, 0, 1));
        seq.push_back(mk(1, 0, 0, 1, 0, 0, SIZE_FULL, SIZE_FULL, 1));
        seq.push_back(mk(1, COORD_MAX - 10, 0, 1, COORD_MAX - 40000, 0, Q_ONE, 100 * Q_ONE, 1));
        seq.push_back(mk(1, COORD_MIN + 10, 0, 1, COORD_MIN + 40000, 0, Q_ONE, 100 * Q_ONE, 1));
        seq.push_back(mk(1, 0, COORD_MAX - 5, 1, 0, COORD_MAX - 30000, 100 * Q_ONE, Q_ONE, 1));
        seq.push_back(mk(1, 0, COORD_MIN + 5, 1, 0, COORD_MIN + 30000, 100 * Q_ONE, Q_ONE, 1));
        seq.push_back(mk(1, COORD_MIN, COORD_MAX, 1, COORD_MAX, COORD_MIN,
                         SIZE_FULL, SIZE_FULL, 1));
        seq.push_back(mk(1, COORD_MAX, COORD_MIN, 1, COORD_MAX, COORD_MIN,
                         SIZE_FULL, SIZE_FULL, 1));
        seq.push_back(mk(1, 123456, -654321, 0, -1, -1, SIZE_FULL, SIZE_FULL, 1));   // empty list
        seq.push_back(mk(1, 0, 0, 1, Q_ONE, 0, Q_ONE, Q_ONE, 0));
        seq.push_back(mk(0, 0, 0, 1, 0, -Q_ONE, Q_ONE / 2, Q_ONE, 0));
        seq.push_back(mk(0, 0, 0, 1, -Q_ONE / 2, Q_ONE / 2, Q_ONE, Q_ONE, 0));
        seq.push_back(mk(0, 0, 0, 1, 3 * Q_ONE, 3 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 1));
        foreach (seq[i]) send_item(seq[i]);
    endtask

    // one check: start, a handful of walls around the player, last; a few are broken
    task automatic run_check();
        t_wall_step  it;
        int          n;
        int          r;
        bit          broken;
        longint      px;
        longint      py;
        int unsigned spread;
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
        broken = ($urandom_range(0, 9) == 0);
        steady_sender = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 70) begin
            px = longint'(near(0, 1 << 22));
            py = longint'(near(0, 1 << 22));
        end else if (r < 85) begin
            px = longint'(t_coord'($urandom));
            py = longint'(t_coord'($urandom));
        end else begin
            px = (r % 2) ? COORD_MAX - $urandom_range(0, 300000)
                         : COORD_MIN + $urandom_range(0, 300000);
            py = (r % 3) ? COORD_MIN + $urandom_range(0, 300000)
                         : COORD_MAX - $urandom_range(0, 300000);
        end
        spread = (sb.size_reg > (1 << 29)) ? (1 << 30) : (sb.size_reg >> 1) + 3 * 65536;
        for (int i = 0; i < n; i++) begin
            it.start = broken ? ($urandom_range(0, 3) == 0) : (i == 0);
            it.px    = it.start ? t_coord'(px) : t_coord'($urandom);
            it.py    = it.start ? t_coord'(py) : t_coord'($urandom);
            it.wall  = ($urandom_range(0, 9) != 0);
            it.ww    = rand_size();
            it.wh    = rand_size();
            it.wx    = ($urandom_range(0, 19) == 0) ? t_coord'($urandom) : near(px, spread);
            it.wy    = ($urandom_range(0, 19) == 0) ? t_coord'($urandom) : near(py, spread);
            it.last  = (i == n - 1) && (!broken || $urandom_range(0, 1));
            send_item(it);
        end
    endtask

    initial begin
        int  goal;
        int  per_phase;
        bit  held_once;
        logic [SIZE_BITS-1:0]   size;
        logic [MARGIN_BITS-1:0] margin;
        sb = new;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        per_phase = (ITEM_TARGET - DIRECTED_N) / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin size = '0;               margin = '0;         end
                1: begin size = SIZE_BITS'(SIZE_FULL); margin = '1;    end
                2: begin size = SIZE_BITS'(3 * 65536); margin = '0;    end
                3: begin size = SIZE_BITS'(1);    margin = '1;         end
                7: begin size = SIZE_RST;         margin = MARGIN_RST; end
                default: begin
                    size   = SIZE_BITS'($urandom_range(1, 4 * 65536));
                    margin = MARGIN_BITS'($urandom);
                end
            endcase
            apply_settings(size, margin);
            goal = items_sent + per_phase;
            while (items_sent < goal) begin
                run_check();
                if ($urandom_range(0, 39) == 0 || (p == 3 && !held_once)) begin
                    wait_drained();
                    held_once = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d items and %0d resolved positions over %0d register settings",
                 items_sent, sb.n_checked, n_settings);
        $display("mismatches found: %0d", sb.n_errors);
        if (sb.n_errors == 0 && sb.expected_pos.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
